// ===== rtl/scbc_pkg.sv =====
package scbc_pkg;

  localparam int NUM_CLASSES    = 8;
  localparam int CLS_W          = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int MIN_BLOCK_BITS = 10;
  localparam int ALIGN_BITS     = 10;
  localparam int STACK_DEPTH    = 64;
  localparam int SLOT_W         = $clog2(STACK_DEPTH);
  localparam int CNT_W          = $clog2(STACK_DEPTH + 1);
  localparam int HANDLE_BITS    = 16;
  localparam int MB_SHIFT       = 20;

  localparam int SIZE_W    = 31;
  localparam int ROUND_W   = 32;
  localparam int HANDLE_W  = 16;
  localparam int CLSIDX_W  = 3;
  localparam int MAXB_W    = 6;
  localparam int MAXMB_W   = 12;
  localparam int CFG_W     = 12;
  localparam int S_DATA_W  = 48;
  localparam int M_DATA_W  = 56;
  localparam int M_USER_W  = 3;

  localparam int RAM_DEPTH = NUM_CLASSES * STACK_DEPTH;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [ROUND_W-1:0] MIN_SIZE = ROUND_W'(1) << MIN_BLOCK_BITS;
  localparam logic [ROUND_W-1:0] MAX_SIZE =
    ROUND_W'(1) << (MIN_BLOCK_BITS + NUM_CLASSES - 1);

  localparam logic [MAXB_W-1:0]  MAXB_RESET  = 6'd63;
  localparam logic [MAXMB_W-1:0] MAXMB_RESET = 12'd64;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic REG_MAX_BLOCKS = 1'b0;
  localparam logic REG_MAX_MB     = 1'b1;

  localparam logic [1:0] ACT_REUSE  = 2'd0;
  localparam logic [1:0] ACT_FRESH  = 2'd1;
  localparam logic [1:0] ACT_CACHED = 2'd2;
  localparam logic [1:0] ACT_DROP   = 2'd3;

  typedef struct packed {
    logic                   op;
    logic                   drop;
    logic                   class_valid;
    logic [CLS_W-1:0]       cls;
    logic [ROUND_W-1:0]     rounded;
    logic [HANDLE_BITS-1:0] handle;
  } job_t;

endpackage

// ===== rtl/size_class_block_cache_top.sv =====
// Size-class block cache: allocate/release requests against per-class
// LIFO stacks of cached block handles.
// s_* channel: request word. tuser = op (0 allocate, 1 release);
//   tdata = req_size, block_handle.
// m_* channel: one result word per request. tuser = action, class_valid;
//   tdata = class_index, rounded_size, handle_out.
// cfg_* channel: register writes, always ready; index 0 is
//   max_blocks_per_class, index 1 is max_megabytes_per_class.
// A request is classified on acceptance into a two-entry queue; the back end
// first reads the class count and accesses the stack RAM, then loads the
// output register from the registered RAM read. The back-end sequencer
// around the single stack RAM takes a new request only after the result
// word of the last one is loaded.
// Reset clears all class counts and restores register defaults; the stack
// RAM needs no clearing. When m_tready is low the result word holds, the
// back end waits, the queue fills and s_tready drops.
module size_class_block_cache_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [scbc_pkg::S_DATA_W-1:0]  s_tdata,  // req_size, block_handle, pad
  input  logic                           s_tuser,  // op
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [scbc_pkg::M_DATA_W-1:0]  m_tdata,  // class_index, rounded_size, handle_out, pad
  output logic [scbc_pkg::M_USER_W-1:0]  m_tuser,  // action, class_valid
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [scbc_pkg::CFG_W-1:0]     cfg_data
);
  import scbc_pkg::*;

  job_t in_job;
  job_t head;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  scbc_front u_front (
    .op           (s_tuser),
    .req_size     (s_tdata[SIZE_W-1:0]),
    .block_handle (s_tdata[SIZE_W+HANDLE_W-1:SIZE_W]),
    .job          (in_job)
  );

  scbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (in_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_valid),
    .head     (head)
  );

  scbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("queue push while full");

  a_out_cleared: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_reuse_class: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] == ACT_REUSE) |-> m_tuser[2])
    else $error("reused handle without a class");

  a_noclass_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[2]) |-> (m_tdata[CLSIDX_W-1:0] == '0))
    else $error("class index set without a class");
`endif

endmodule

// ===== rtl/scbc_ram.sv =====
module scbc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/scbc_front.sv =====
module scbc_front (
  input  logic                                op,
  input  logic [scbc_pkg::SIZE_W-1:0]         req_size,
  input  logic [scbc_pkg::HANDLE_W-1:0]       block_handle,
  output scbc_pkg::job_t                      job
);
  import scbc_pkg::*;

  logic [SIZE_W-1:0]  units;
  logic [CLS_W-1:0]   fl;
  logic [ROUND_W-1:0] size32;
  logic [ROUND_W-1:0] bs;
  logic [ROUND_W-1:0] aligned;

  // floor log2 of size in minimum-block units
  always_comb begin
    units = req_size >> MIN_BLOCK_BITS;
    fl    = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (units[i]) begin
        fl = CLS_W'(i);
      end
    end
  end

  assign size32  = {1'b0, req_size};
  assign bs      = MIN_SIZE << fl;
  assign aligned = (size32 >> ALIGN_BITS) + ROUND_W'(1);

  always_comb begin
    job.op          = op;
    job.drop        = 1'b0;
    job.class_valid = 1'b0;
    job.cls         = '0;
    job.rounded     = '0;
    job.handle      = block_handle[HANDLE_BITS-1:0];
    if (op == OP_ALLOC) begin
      if (size32 <= MIN_SIZE) begin
        job.class_valid = 1'b1;
        job.rounded     = MIN_SIZE;
      end else if (size32 > MAX_SIZE) begin
        job.rounded = aligned << ALIGN_BITS;
      end else begin
        job.class_valid = 1'b1;
        if (bs < size32) begin
          job.cls     = (fl == CLS_W'(NUM_CLASSES - 1)) ? fl : fl + CLS_W'(1);
          job.rounded = bs << 1;
        end else begin
          job.cls     = fl;
          job.rounded = bs;
        end
      end
    end else begin
      if (size32 < MIN_SIZE || size32 > MAX_SIZE) begin
        job.drop = 1'b1;
      end else begin
        job.class_valid = 1'b1;
        job.cls         = fl;
      end
    end
  end

endmodule

// ===== rtl/scbc_queue.sv =====
module scbc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scbc_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output scbc_pkg::job_t head
);
  import scbc_pkg::*;

  job_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/scbc_back.sv =====
module scbc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  scbc_pkg::job_t                 head,
  output logic                           q_pop,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [scbc_pkg::CFG_W-1:0]     cfg_data,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [scbc_pkg::M_DATA_W-1:0]  m_tdata,
  output logic [scbc_pkg::M_USER_W-1:0]  m_tuser
);
  import scbc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DONE = 1'b1;

  logic                   state;
  logic [CNT_W-1:0]       cnt [NUM_CLASSES];
  logic [MAXB_W-1:0]      max_blocks;
  logic [MAXMB_W-1:0]     max_mb;

  logic [1:0]             p_action;
  logic                   p_valid;
  logic [CLS_W-1:0]       p_cls;
  logic [ROUND_W-1:0]     p_rounded;

  logic [CNT_W-1:0]       c;
  logic [CNT_W-1:0]       c_dec;
  logic [ROUND_W-1:0]     bytes;
  logic                   over;
  logic [1:0]             act;
  logic                   ram_we;
  logic                   ram_re;
  logic [CLS_W+SLOT_W-1:0] waddr;
  logic [CLS_W+SLOT_W-1:0] raddr;
  logic [HANDLE_BITS-1:0] rdata;
  logic                   out_free;
  logic [HANDLE_W-1:0]    hout;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign q_pop     = (state == ST_IDLE) && q_valid;

  assign c     = cnt[head.cls];
  assign c_dec = c - CNT_W'(1);
  assign bytes = (ROUND_W'(c) << MIN_BLOCK_BITS) << head.cls;
  assign over  = (c > CNT_W'(max_blocks)) ||
                 ((bytes >> MB_SHIFT) > ROUND_W'(max_mb)) ||
                 (c >= CNT_W'(STACK_DEPTH));
  assign waddr = {head.cls, c[SLOT_W-1:0]};
  assign raddr = {head.cls, c_dec[SLOT_W-1:0]};

  always_comb begin
    act    = ACT_FRESH;
    ram_we = 1'b0;
    ram_re = 1'b0;
    if (head.op == OP_ALLOC) begin
      if (head.class_valid && c != '0) begin
        act    = ACT_REUSE;
        ram_re = q_pop;
      end
    end else begin
      if (head.drop || over) begin
        act = ACT_DROP;
      end else begin
        act    = ACT_CACHED;
        ram_we = q_pop;
      end
    end
  end

  scbc_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (head.handle),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_blocks <= MAXB_RESET;
      max_mb     <= MAXMB_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_BLOCKS: max_blocks <= cfg_data[MAXB_W-1:0];
        REG_MAX_MB:     max_mb     <= cfg_data[MAXMB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cnt[i] <= '0;
      end
    end else if (ram_re) begin
      cnt[head.cls] <= c_dec;
    end else if (ram_we) begin
      cnt[head.cls] <= c + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_action  <= act;
      p_valid   <= head.class_valid;
      p_cls     <= head.cls;
      p_rounded <= head.rounded;
    end
  end

  assign hout = (p_action == ACT_REUSE) ? HANDLE_W'(rdata) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            state <= ST_DONE;
          end
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {(M_DATA_W - HANDLE_W - ROUND_W - CLSIDX_W)'(0), hout, p_rounded,
                  CLSIDX_W'(p_cls)};
      m_tuser <= {p_valid, p_action};
    end
  end

endmodule
